// File: sv/htfe_pkg.sv
// Package for the header/tail frame extractor: shared constants, configuration
// register indexes and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package htfe_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned MAX_FIXED_LENGTH_DEF = 6;
  localparam int unsigned TEST_LENGTH = 4;
  localparam int unsigned PARAM_LENGTH = 6;

  localparam logic [LEN_W-1:0] TAIL_SEARCH_START = 3'd2;
  localparam logic [LEN_W-1:0] VAR_HEAD_LEN = 3'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_BYTE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEST_COMMAND = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PARAM_READ_COMMAND = 2'd3;

  localparam logic [BYTE_W-1:0] HEADER_BYTE_RST = 8'd170;
  localparam logic [BYTE_W-1:0] TAIL_BYTE_RST = 8'd10;
  localparam logic [BYTE_W-1:0] TEST_COMMAND_RST = 8'd0;
  localparam logic [BYTE_W-1:0] PARAM_READ_COMMAND_RST = 8'd16;

  typedef struct packed {
    logic             take;
    logic             emit;
    logic [LEN_W-1:0] emit_idx;
    logic             emit_first;
    logic             emit_last;
  } cmd_t;

  typedef struct packed {
    logic             burst;
    logic             single;
    logic [LEN_W-1:0] burst_len;
    logic             burst_tail;
  } status_t;

endpackage

// File: sv/htfe_if.sv
// Stream interfaces of the frame extractor: the received-byte channel and the
// frame-byte channel, each with valid/ready handshake. Depends on htfe_pkg.
`timescale 1ns / 1ps

interface htfe_rx_if;
  logic                        valid;
  logic                        ready;
  logic [htfe_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface htfe_frame_if;
  logic                        valid;
  logic                        ready;
  logic [htfe_pkg::BYTE_W-1:0] frame_byte;
  logic                        frame_first;
  logic                        frame_last;

  modport source (output valid, output frame_byte, output frame_first, output frame_last,
                  input ready);
  modport sink (input valid, input frame_byte, input frame_first, input frame_last,
                output ready);
endinterface

// File: sv/htfe_dpath.sv
// Datapath of the frame extractor: configuration registers, frame parser state,
// held frame bytes and the output payload register. Depends on htfe_pkg.
`timescale 1ns / 1ps

module htfe_dpath #(
  parameter int unsigned MAX_FIXED_LENGTH = htfe_pkg::MAX_FIXED_LENGTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [htfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [htfe_pkg::BYTE_W-1:0]    cfg_wdata,
  input  logic [htfe_pkg::BYTE_W-1:0]    rx_byte,
  input  htfe_pkg::cmd_t                 cmd,
  output htfe_pkg::status_t              status,
  output logic [htfe_pkg::BYTE_W-1:0]    frame_byte,
  output logic                           frame_first,
  output logic                           frame_last
);

  localparam int unsigned TEST_LEN =
    (htfe_pkg::TEST_LENGTH > MAX_FIXED_LENGTH) ? MAX_FIXED_LENGTH : htfe_pkg::TEST_LENGTH;
  localparam int unsigned PARAM_LEN =
    (htfe_pkg::PARAM_LENGTH > MAX_FIXED_LENGTH) ? MAX_FIXED_LENGTH : htfe_pkg::PARAM_LENGTH;
  localparam int unsigned HELD_DEPTH = (PARAM_LEN > TEST_LEN) ? PARAM_LEN : TEST_LEN;
  localparam int unsigned HIDX_W = $clog2(HELD_DEPTH);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_CMD,
    PH_FIXED,
    PH_VAR
  } phase_t;

  logic [htfe_pkg::BYTE_W-1:0] header_r, tail_r, test_cmd_r, param_cmd_r;
  phase_t                      phase_r, phase_nxt;
  logic [htfe_pkg::LEN_W-1:0]  pos_r, pos_nxt, flen_r, flen_nxt, pos_inc;
  logic [htfe_pkg::BYTE_W-1:0] held_r [HELD_DEPTH];
  logic                        held_we;
  logic [HIDX_W-1:0]           held_waddr;
  logic                        is_tail;

  assign pos_inc = pos_r + 3'd1;
  assign is_tail = (rx_byte == tail_r);

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    flen_nxt   = flen_r;
    held_we    = 1'b0;
    held_waddr = pos_r[HIDX_W-1:0];
    status     = '0;
    case (phase_r)
      PH_HUNT: begin
        if (rx_byte == header_r) begin
          held_we    = 1'b1;
          held_waddr = HIDX_W'(0);
          pos_nxt    = 3'd1;
          phase_nxt  = PH_CMD;
        end
      end
      PH_CMD: begin
        held_we    = 1'b1;
        held_waddr = HIDX_W'(1);
        pos_nxt    = htfe_pkg::TAIL_SEARCH_START;
        if (rx_byte == test_cmd_r) begin
          flen_nxt  = htfe_pkg::LEN_W'(TEST_LEN);
          phase_nxt = PH_FIXED;
        end else if (rx_byte == param_cmd_r) begin
          flen_nxt  = htfe_pkg::LEN_W'(PARAM_LEN);
          phase_nxt = PH_FIXED;
        end else begin
          phase_nxt = PH_VAR;
        end
      end
      PH_FIXED: begin
        held_we = 1'b1;
        pos_nxt = pos_inc;
        if (pos_inc >= flen_r) begin
          phase_nxt = PH_HUNT;
          pos_nxt   = '0;
          if (is_tail) begin
            status.burst      = 1'b1;
            status.burst_len  = flen_r;
            status.burst_tail = 1'b1;
          end
        end
      end
      PH_VAR: begin
        if (pos_r <= htfe_pkg::TAIL_SEARCH_START) begin
          if (is_tail) begin
            phase_nxt = PH_HUNT;
            pos_nxt   = '0;
          end else begin
            held_we          = 1'b1;
            held_waddr       = htfe_pkg::TAIL_SEARCH_START[HIDX_W-1:0];
            status.burst     = 1'b1;
            status.burst_len = htfe_pkg::VAR_HEAD_LEN;
            pos_nxt          = htfe_pkg::VAR_HEAD_LEN;
          end
        end else begin
          status.single = 1'b1;
          if (is_tail) begin
            phase_nxt = PH_HUNT;
            pos_nxt   = '0;
          end
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        pos_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r    <= htfe_pkg::HEADER_BYTE_RST;
      tail_r      <= htfe_pkg::TAIL_BYTE_RST;
      test_cmd_r  <= htfe_pkg::TEST_COMMAND_RST;
      param_cmd_r <= htfe_pkg::PARAM_READ_COMMAND_RST;
      phase_r     <= PH_HUNT;
      pos_r       <= '0;
      flen_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          htfe_pkg::CFG_HEADER_BYTE:        header_r    <= cfg_wdata;
          htfe_pkg::CFG_TAIL_BYTE:          tail_r      <= cfg_wdata;
          htfe_pkg::CFG_TEST_COMMAND:       test_cmd_r  <= cfg_wdata;
          htfe_pkg::CFG_PARAM_READ_COMMAND: param_cmd_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.take) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        flen_r  <= flen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && held_we) begin
      held_r[held_waddr] <= rx_byte;
    end
    if (cmd.take && status.single) begin
      frame_byte  <= rx_byte;
      frame_first <= 1'b0;
      frame_last  <= is_tail;
    end else if (cmd.emit) begin
      frame_byte  <= held_r[cmd.emit_idx[HIDX_W-1:0]];
      frame_first <= cmd.emit_first;
      frame_last  <= cmd.emit_last;
    end
  end

endmodule

// File: sv/htfe_ctrl.sv
// Controller of the frame extractor: input/output handshake, burst sequencing of
// held frame bytes and output valid. Depends on htfe_pkg.
`timescale 1ns / 1ps

module htfe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  htfe_pkg::status_t status,
  output htfe_pkg::cmd_t    cmd
);

  typedef enum logic {
    ST_TAKE,
    ST_BURST
  } state_t;

  state_t                     state_r, state_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [htfe_pkg::LEN_W-1:0] idx_r, idx_nxt, len_r, len_nxt;
  logic                       tail_r, tail_nxt;
  logic                       slot_free, idx_at_end;

  assign slot_free  = !out_valid_r || out_ready;
  assign idx_at_end = (idx_r == (len_r - 3'd1));
  assign in_ready   = (state_r == ST_TAKE) && slot_free;
  assign out_valid  = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    idx_nxt        = idx_r;
    len_nxt        = len_r;
    tail_nxt       = tail_r;
    cmd.take       = in_valid && in_ready;
    cmd.emit       = 1'b0;
    cmd.emit_idx   = idx_r;
    cmd.emit_first = (idx_r == '0);
    cmd.emit_last  = tail_r && idx_at_end;
    case (state_r)
      ST_TAKE: begin
        if (cmd.take) begin
          if (status.single) begin
            out_valid_nxt = 1'b1;
          end else if (status.burst) begin
            len_nxt   = status.burst_len;
            tail_nxt  = status.burst_tail;
            idx_nxt   = '0;
            state_nxt = ST_BURST;
          end
        end
      end
      ST_BURST: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          idx_nxt       = idx_r + 3'd1;
          if (idx_at_end) begin
            state_nxt = ST_TAKE;
          end
        end
      end
      default: state_nxt = ST_TAKE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_TAKE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      len_r       <= '0;
      tail_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      len_r       <= len_nxt;
      tail_r      <= tail_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BURST) |-> (idx_r < len_r))
    else $error("burst index past burst length");

  a_burst_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BURST) |-> (len_r >= 3'd3 && len_r <= 3'd6))
    else $error("illegal burst length");

  a_burst_entered: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && status.burst) |=> (state_r == ST_BURST && idx_r == '0))
    else $error("burst not started after closing transaction");

  a_status_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(status.burst && status.single))
    else $error("burst and single result requested together");

  a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("emitted byte not presented");
`endif

endmodule

// File: sv/header_tail_frame_extractor_unit.sv
// Output: a streamed variable-frame byte is presented in the cycle after its transaction;
// a held burst (fixed frame, or the first three bytes of a variable frame) starts after the
// burst state is entered, goes through the output register and delivers one byte per cycle
// while out is ready. Throughput: one input transaction per cycle outside bursts and stalls.
// Reset: synchronous active-low rst_n restores register defaults and header hunting.
`timescale 1ns / 1ps

module header_tail_frame_extractor_unit #(
  parameter int unsigned MAX_FIXED_LENGTH = htfe_pkg::MAX_FIXED_LENGTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  htfe_rx_if.sink                        in_ch,
  htfe_frame_if.source                   out_ch,
  input  logic                           cfg_we,
  input  logic [htfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [htfe_pkg::BYTE_W-1:0]    cfg_wdata
);

  htfe_pkg::cmd_t    cmd;
  htfe_pkg::status_t status;

  htfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  htfe_dpath #(
    .MAX_FIXED_LENGTH (MAX_FIXED_LENGTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .rx_byte     (in_ch.rx_byte),
    .cmd         (cmd),
    .status      (status),
    .frame_byte  (out_ch.frame_byte),
    .frame_first (out_ch.frame_first),
    .frame_last  (out_ch.frame_last)
  );

endmodule

// File: bench/tb_header_tail_frame_extractor_unit.sv
// Self-checking testbench for header_tail_frame_extractor_unit: it drives received bytes,
// predicts the extracted frame bytes, and checks every frame transaction in order.
// Depends on htfe_pkg, the htfe_rx_if/htfe_frame_if interfaces and the unit itself.
`timescale 1ns / 1ps

module tb_header_tail_frame_extractor_unit;

  localparam int unsigned BYTE_W = htfe_pkg::BYTE_W;
  localparam int unsigned LEN_W = htfe_pkg::LEN_W;
  localparam int unsigned CFG_IDX_W = htfe_pkg::CFG_IDX_W;
  localparam int unsigned MAX_HELD = htfe_pkg::MAX_FIXED_LENGTH_DEF;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RANDOM_ITEMS_PER_SETTING = 26;

  typedef enum logic [1:0] {SCAN_HEADER, TAKE_COMMAND, HOLD_FIXED, STREAM_VAR} parse_phase_t;
  typedef enum logic [1:0] {SINK_OPEN, SINK_CHOPPY, SINK_SLOW} sink_mode_t;
  typedef enum logic [2:0] {FK_TEST, FK_PARAM, FK_BAD_TAIL, FK_VAR, FK_NOISE} frame_kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              last;
  } frame_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_wdata;

  htfe_rx_if    rx_if();
  htfe_frame_if frame_if();

  header_tail_frame_extractor_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (rx_if),
    .out_ch    (frame_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [BYTE_W-1:0] header_q;
  logic [BYTE_W-1:0] tail_q;
  logic [BYTE_W-1:0] test_cmd_q;
  logic [BYTE_W-1:0] param_cmd_q;

  parse_phase_t      parse_phase;
  logic [LEN_W-1:0]  frame_pos;
  logic [LEN_W-1:0]  fixed_len;
  logic [BYTE_W-1:0] held_bytes_q [MAX_HELD];

  frame_beat_t pending_frame_bytes[$];
  frame_beat_t want;

  int unsigned mismatches = 0;
  int unsigned frame_bytes_checked = 0;
  int unsigned rx_bytes_sent;
  int unsigned frame_items;
  int unsigned settings_applied;
  int unsigned burst_left;

  sink_mode_t  sink_mode;
  int unsigned sink_span;

  always #6 clk = ~clk;

  function automatic logic [LEN_W-1:0] clamp_frame_len(input int unsigned n);
    return (n > MAX_HELD) ? LEN_W'(MAX_HELD) : LEN_W'(n);
  endfunction

  task automatic push_beat(input logic [BYTE_W-1:0] data, input logic first, input logic last);
    frame_beat_t beat;
    beat.data = data;
    beat.first = first;
    beat.last = last;
    pending_frame_bytes.push_back(beat);
  endtask

  task automatic extract_frames(input logic [BYTE_W-1:0] b);
    int unsigned i;
    case (parse_phase)
      SCAN_HEADER: begin
        if (b == header_q) begin
          held_bytes_q[0] = b;
          frame_pos = 3'd1;
          parse_phase = TAKE_COMMAND;
        end
      end
      TAKE_COMMAND: begin
        held_bytes_q[1] = b;
        frame_pos = 3'd2;
        if (b == test_cmd_q) begin
          fixed_len = clamp_frame_len(htfe_pkg::TEST_LENGTH);
          parse_phase = HOLD_FIXED;
        end else if (b == param_cmd_q) begin
          fixed_len = clamp_frame_len(htfe_pkg::PARAM_LENGTH);
          parse_phase = HOLD_FIXED;
        end else begin
          parse_phase = STREAM_VAR;
        end
      end
      HOLD_FIXED: begin
        if (frame_pos < MAX_HELD) held_bytes_q[frame_pos] = b;
        frame_pos = frame_pos + 3'd1;
        if (frame_pos >= fixed_len) begin
          if (b == tail_q) begin
            for (i = 0; i < fixed_len && i < MAX_HELD; i++) begin
              push_beat(held_bytes_q[i], i == 0, i + 1 == fixed_len);
            end
          end
          parse_phase = SCAN_HEADER;
          frame_pos = '0;
        end
      end
      default: begin
        if (frame_pos <= htfe_pkg::TAIL_SEARCH_START) begin
          if (b == tail_q) begin
            parse_phase = SCAN_HEADER;
            frame_pos = '0;
          end else begin
            push_beat(held_bytes_q[0], 1'b1, 1'b0);
            push_beat(held_bytes_q[1], 1'b0, 1'b0);
            push_beat(b, 1'b0, 1'b0);
            frame_pos = htfe_pkg::TAIL_SEARCH_START + 3'd1;
          end
        end else begin
          push_beat(b, 1'b0, b == tail_q);
          if (b == tail_q) begin
            parse_phase = SCAN_HEADER;
            frame_pos = '0;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sink_mode <= SINK_OPEN;
      sink_span <= 0;
      frame_if.ready <= 1'b0;
    end else begin
      if (sink_span == 0) begin
        sink_mode <= sink_mode_t'($urandom_range(0, 2));
        sink_span <= $urandom_range(16, 64);
      end else begin
        sink_span <= sink_span - 1;
      end
      case (sink_mode)
        SINK_OPEN: frame_if.ready <= 1'b1;
        SINK_CHOPPY: frame_if.ready <= 1'($urandom_range(0, 1));
        default: frame_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && frame_if.valid && frame_if.ready) begin
      if (pending_frame_bytes.size() == 0) begin
        $error("unexpected frame transaction: frame_byte %0h first %0b last %0b",
               frame_if.frame_byte, frame_if.frame_first, frame_if.frame_last);
        mismatches++;
      end else begin
        want = pending_frame_bytes.pop_front();
        frame_bytes_checked++;
        if (frame_if.frame_byte !== want.data) begin
          $error("frame_byte: expected %0h, actual %0h", want.data, frame_if.frame_byte);
          mismatches++;
        end
        if (frame_if.frame_first !== want.first) begin
          $error("frame_first: expected %0b, actual %0b", want.first, frame_if.frame_first);
          mismatches++;
        end
        if (frame_if.frame_last !== want.last) begin
          $error("frame_last: expected %0b, actual %0b", want.last, frame_if.frame_last);
          mismatches++;
        end
      end
    end
  end

  task automatic send_rx(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    extract_frames(b);
    rx_bytes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
  endtask

  task automatic wait_frames_drained();
    rx_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_frame_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      htfe_pkg::CFG_HEADER_BYTE: header_q = value;
      htfe_pkg::CFG_TAIL_BYTE: tail_q = value;
      htfe_pkg::CFG_TEST_COMMAND: test_cmd_q = value;
      default: param_cmd_q = value;
    endcase
  endtask

  task automatic program_registers(input logic [BYTE_W-1:0] header, input logic [BYTE_W-1:0] tail,
                                   input logic [BYTE_W-1:0] test_cmd,
                                   input logic [BYTE_W-1:0] param_cmd);
    write_reg(htfe_pkg::CFG_HEADER_BYTE, header);
    write_reg(htfe_pkg::CFG_TAIL_BYTE, tail);
    write_reg(htfe_pkg::CFG_TEST_COMMAND, test_cmd);
    write_reg(htfe_pkg::CFG_PARAM_READ_COMMAND, param_cmd);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_applied++;
  endtask

  task automatic close_open_frame();
    while (parse_phase != SCAN_HEADER) send_rx(tail_q);
  endtask

  task automatic send_random_frame();
    int unsigned pick;
    int unsigned body;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] b;
    frame_kind_t kind;
    pick = $urandom_range(0, 9);
    kind = (pick < 3) ? FK_TEST : (pick < 5) ? FK_PARAM : (pick < 6) ? FK_BAD_TAIL :
           (pick < 9) ? FK_VAR : FK_NOISE;
    case (kind)
      FK_NOISE: begin
        repeat ($urandom_range(1, 4)) send_rx(BYTE_W'($urandom_range(0, 255)));
      end
      FK_VAR: begin
        do cmd = BYTE_W'($urandom_range(0, 255));
        while (cmd == test_cmd_q || cmd == param_cmd_q);
        body = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 14) : $urandom_range(0, 5);
        send_rx(header_q);
        send_rx(cmd);
        repeat (body) begin
          do b = BYTE_W'($urandom_range(0, 255));
          while (b == tail_q);
          send_rx(b);
        end
        send_rx(tail_q);
        frame_items += body + 3;
      end
      default: begin
        if (kind == FK_BAD_TAIL) kind = $urandom_range(0, 1) ? FK_PARAM : FK_TEST;
        else pick = 0;
        cmd = (kind == FK_PARAM) ? param_cmd_q : test_cmd_q;
        body = (kind == FK_PARAM) ? htfe_pkg::PARAM_LENGTH - 3 : htfe_pkg::TEST_LENGTH - 3;
        send_rx(header_q);
        send_rx(cmd);
        repeat (body) send_rx(BYTE_W'($urandom_range(0, 255)));
        if (pick == 5) begin
          do b = BYTE_W'($urandom_range(0, 255));
          while (b == tail_q);
          send_rx(b);
        end else begin
          send_rx(tail_q);
        end
        frame_items += body + 3;
      end
    endcase
  endtask

  // Reset defaults: noise, good test and parameter frames, a dropped fixed frame,
  // a dropped three-byte frame and a streamed variable frame.
  task automatic test_defaults();
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(8'h55);
    send_rx(8'hAA); send_rx(8'h00); send_rx(8'hFF); send_rx(8'h0A);
    send_rx(8'hAA); send_rx(8'h10); send_rx(8'h00); send_rx(8'hFF); send_rx(8'h80);
    send_rx(8'h0A);
    send_rx(8'hAA); send_rx(8'h00); send_rx(8'h01); send_rx(8'h0B);
    send_rx(8'hAA); send_rx(8'h77); send_rx(8'h0A);
    send_rx(8'hAA); send_rx(8'h77); send_rx(8'hFF); send_rx(8'h00); send_rx(8'h0A);
    wait_frames_drained();
  endtask

  // When both command registers hold the same code, the four-byte frame wins.
  task automatic test_equal_commands();
    program_registers(8'hFF, 8'h00, 8'h5A, 8'h5A);
    send_rx(8'hFF); send_rx(8'h5A); send_rx(8'h12); send_rx(8'h00);
    wait_frames_drained();
  endtask

  // A tail change while a fixed frame is held applies to the byte that follows.
  task automatic test_midframe_write();
    program_registers(8'hAA, 8'h0A, 8'h00, 8'h10);
    send_rx(8'hAA); send_rx(8'h00); send_rx(8'h33);
    wait_frames_drained();
    write_reg(htfe_pkg::CFG_TAIL_BYTE, 8'h3C);
    cfg_we <= 1'b0;
    send_rx(8'h3C);
    wait_frames_drained();
  endtask

  task automatic run_random_setting(input logic [BYTE_W-1:0] header, input logic [BYTE_W-1:0] tail,
                                    input logic [BYTE_W-1:0] test_cmd,
                                    input logic [BYTE_W-1:0] param_cmd);
    int unsigned target;
    program_registers(header, tail, test_cmd, param_cmd);
    target = frame_items + RANDOM_ITEMS_PER_SETTING;
    while (frame_items < target) begin
      send_random_frame();
      if ($urandom_range(0, 11) == 0) wait_frames_drained();
    end
    close_open_frame();
    wait_frames_drained();
  endtask

  task automatic test_random_traffic();
    logic [BYTE_W-1:0] shared_cmd;
    run_random_setting(8'hAA, 8'h0A, 8'h00, 8'h10);
    run_random_setting(8'h00, 8'hFF, 8'hFF, 8'h00);
    run_random_setting(8'hFF, 8'h00, 8'h00, 8'hFF);
    run_random_setting(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                       BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
    shared_cmd = BYTE_W'($urandom_range(0, 255));
    run_random_setting(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                       shared_cmd, shared_cmd);
    run_random_setting(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                       BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    rx_if.valid <= 1'b0;
    rx_if.rx_byte <= '0;
    header_q = htfe_pkg::HEADER_BYTE_RST;
    tail_q = htfe_pkg::TAIL_BYTE_RST;
    test_cmd_q = htfe_pkg::TEST_COMMAND_RST;
    param_cmd_q = htfe_pkg::PARAM_READ_COMMAND_RST;
    parse_phase = SCAN_HEADER;
    frame_pos = '0;
    fixed_len = '0;
    rx_bytes_sent = 0;
    frame_items = 0;
    settings_applied = 0;
    burst_left = $urandom_range(1, 20);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_equal_commands();
    test_midframe_write();
    test_random_traffic();
    wait_frames_drained();
    $display("Sent %0d received bytes under %0d register settings plus reset defaults.",
             rx_bytes_sent, settings_applied);
    $display("Checked %0d frame bytes with random source gaps and sink stalls.",
             frame_bytes_checked);
    if (mismatches == 0) begin
      $display("header_tail_frame_extractor_unit: match");
    end else begin
      $display("header_tail_frame_extractor_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d frame bytes still expected.", pending_frame_bytes.size());
    $display("header_tail_frame_extractor_unit: mismatch");
    $finish;
  end

endmodule
